FILE: rtl/gia_pkg.sv
package gia_pkg;

    localparam int W      = 32;          // operand / result part width
    localparam int PW     = 2 * W;       // exact product width
    localparam int VW     = 2 * W + 1;   // exact sum of two products
    localparam int MW     = 2 * W;       // magnitude width
    localparam int OW     = 32;          // port width of a result part
    localparam int NSTAGE = MW;          // one quotient bit per divider stage

    typedef enum logic [1:0] {
        FUNC_ADD = 2'd0,
        FUNC_SUB = 2'd1,
        FUNC_MUL = 2'd2,
        FUNC_DIV = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DIV_ZERO = 2'd1,
        ST_INEXACT  = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    // products and add/sub results after the first stage
    typedef struct packed {
        func_t              func;
        logic signed [PW-1:0] p_rr;
        logic signed [PW-1:0] p_ii;
        logic signed [PW-1:0] p_ri;
        logic signed [PW-1:0] p_ir;
        logic signed [PW-1:0] sq_r;
        logic signed [PW-1:0] sq_i;
        logic signed [W:0]    s_re;
        logic signed [W:0]    s_im;
    } prod_t;

    // exact signed results before the divider
    typedef struct packed {
        logic                 is_div;
        logic signed [VW-1:0] v_re;
        logic signed [VW-1:0] v_im;
        logic [MW-1:0]        den;
    } sum_t;

    // divider working set; num shifts quotient bits in from the bottom
    typedef struct packed {
        logic          den_zero;
        logic          neg_re;
        logic          neg_im;
        logic [MW-1:0] den;
        logic [MW-1:0] num_re;
        logic [MW-1:0] num_im;
        logic [MW-1:0] rem_re;
        logic [MW-1:0] rem_im;
    } div_t;

endpackage

FILE: rtl/gaussian_integer_alu_core.sv
// Gaussian integer ALU: add, subtract, multiply or exact divide of two
// complex integers per beat.
// Input channel s_*: s_func selects the operation, s_a_re/s_a_im/s_b_re/
// s_b_im are two's-complement operand parts. A beat moves on s_valid &&
// s_ready.
// Result channel m_*: m_res_re, m_res_im and m_status (ok, divide by zero,
// inexact, overflow), one result beat per input beat, in order.
// Stages, in order: one multiply stage, two stages of sums and sign split,
// 64 restoring divider stages (one quotient bit each; non-divide ops pass
// through them as a divide by one) and an output stage, the same for every
// operation. One beat per cycle is taken while the output is not stalled.
// The whole pipeline advances on one enable; when m_valid is high and
// m_ready low everything holds and s_ready drops, so nothing is lost or
// repeated. Bubbles travel as cleared valid bits.
// Reset (aresetn low, synchronous) clears all valid bits; the pipeline is
// empty and s_ready high right after.
module gaussian_integer_alu_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [31:0] s_a_re,
    input  logic [31:0] s_a_im,
    input  logic [31:0] s_b_re,
    input  logic [31:0] s_b_im,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_res_re,
    output logic [31:0] m_res_im,
    output logic [1:0]  m_status
);

    logic                 en;
    logic                 mul_valid;
    gia_pkg::prod_t       mul_data;
    logic [gia_pkg::NSTAGE:0] dv;
    gia_pkg::div_t        dd [gia_pkg::NSTAGE+1];

    gia_pkg::div_t        fin;
    logic                 fits_re, fits_im;
    logic [gia_pkg::W-1:0] bits_re, bits_im;
    logic [gia_pkg::OW-1:0] res_re_next, res_im_next;
    gia_pkg::status_t     status_next;
    logic                 valid_reg;
    logic [gia_pkg::OW-1:0] res_re_reg, res_im_reg;
    gia_pkg::status_t     status_reg;

    localparam logic [gia_pkg::MW-1:0] Lim = gia_pkg::MW'(1) << (gia_pkg::W - 1);

    assign en      = !valid_reg || m_ready;
    assign s_ready = en;

    gia_mul u_mul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .func      (s_func),
        .a_re      (s_a_re),
        .a_im      (s_a_im),
        .b_re      (s_b_re),
        .b_im      (s_b_im),
        .out_valid (mul_valid),
        .out_data  (mul_data)
    );

    gia_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (mul_valid),
        .in_data   (mul_data),
        .out_valid (dv[0]),
        .out_data  (dd[0])
    );

    for (genvar i = 0; i < gia_pkg::NSTAGE; i++) begin : g_div
        gia_dstage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (dv[i]),
            .in_data   (dd[i]),
            .out_valid (dv[i+1]),
            .out_data  (dd[i+1])
        );
    end

    assign fin = dd[gia_pkg::NSTAGE];

    // negative side may reach -2^(W-1)
    assign fits_re = fin.neg_re ? (fin.num_re <= Lim) : (fin.num_re < Lim);
    assign fits_im = fin.neg_im ? (fin.num_im <= Lim) : (fin.num_im < Lim);
    assign bits_re = fin.neg_re ? -fin.num_re[gia_pkg::W-1:0] : fin.num_re[gia_pkg::W-1:0];
    assign bits_im = fin.neg_im ? -fin.num_im[gia_pkg::W-1:0] : fin.num_im[gia_pkg::W-1:0];

    always_comb begin
        res_re_next = gia_pkg::OW'(signed'(bits_re));
        res_im_next = gia_pkg::OW'(signed'(bits_im));
        status_next = gia_pkg::ST_OK;
        if (fin.den_zero) begin
            status_next = gia_pkg::ST_DIV_ZERO;
            res_re_next = '0;
            res_im_next = '0;
        end else if (fin.rem_re != '0 || fin.rem_im != '0) begin
            status_next = gia_pkg::ST_INEXACT;
            res_re_next = '0;
            res_im_next = '0;
        end else if (!fits_re || !fits_im) begin
            status_next = gia_pkg::ST_OVERFLOW;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= dv[gia_pkg::NSTAGE];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_re_reg <= res_re_next;
            res_im_reg <= res_im_next;
            status_reg <= status_next;
        end
    end

    assign m_valid  = valid_reg;
    assign m_res_re = res_re_reg;
    assign m_res_im = res_im_reg;
    assign m_status = status_reg;

endmodule

FILE: rtl/gia_mul.sv
module gia_mul (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [1:0]           func,
    input  logic [31:0]          a_re,
    input  logic [31:0]          a_im,
    input  logic [31:0]          b_re,
    input  logic [31:0]          b_im,
    output logic                 out_valid,
    output gia_pkg::prod_t       out_data
);

    logic signed [gia_pkg::W-1:0] ar, ai, br, bi;
    gia_pkg::prod_t               data_next;
    gia_pkg::prod_t               data_reg;
    logic                         valid_reg;

    assign ar = a_re[gia_pkg::W-1:0];
    assign ai = a_im[gia_pkg::W-1:0];
    assign br = b_re[gia_pkg::W-1:0];
    assign bi = b_im[gia_pkg::W-1:0];

    always_comb begin
        data_next.func = gia_pkg::func_t'(func);
        data_next.p_rr = ar * br;
        data_next.p_ii = ai * bi;
        data_next.p_ri = ar * bi;
        data_next.p_ir = ai * br;
        data_next.sq_r = br * br;
        data_next.sq_i = bi * bi;
        if (gia_pkg::func_t'(func) == gia_pkg::FUNC_SUB) begin
            data_next.s_re = (gia_pkg::W+1)'(ar) - (gia_pkg::W+1)'(br);
            data_next.s_im = (gia_pkg::W+1)'(ai) - (gia_pkg::W+1)'(bi);
        end else begin
            data_next.s_re = (gia_pkg::W+1)'(ar) + (gia_pkg::W+1)'(br);
            data_next.s_im = (gia_pkg::W+1)'(ai) + (gia_pkg::W+1)'(bi);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: rtl/gia_prep.sv
module gia_prep (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           in_valid,
    input  gia_pkg::prod_t in_data,
    output logic           out_valid,
    output gia_pkg::div_t  out_data
);

    gia_pkg::sum_t sum_next, sum_reg;
    gia_pkg::div_t div_next, div_reg;
    logic          sum_valid_reg, div_valid_reg;
    logic signed [gia_pkg::VW-1:0] neg_re, neg_im;

    // stage A: exact signed results; non-divide ops divide by one
    always_comb begin
        sum_next.is_div = 1'b0;
        sum_next.den    = gia_pkg::MW'(1);
        case (in_data.func)
            gia_pkg::FUNC_ADD, gia_pkg::FUNC_SUB: begin
                sum_next.v_re = gia_pkg::VW'(in_data.s_re);
                sum_next.v_im = gia_pkg::VW'(in_data.s_im);
            end
            gia_pkg::FUNC_MUL: begin
                sum_next.v_re = gia_pkg::VW'(in_data.p_rr) - gia_pkg::VW'(in_data.p_ii);
                sum_next.v_im = gia_pkg::VW'(in_data.p_ri) + gia_pkg::VW'(in_data.p_ir);
            end
            default: begin
                sum_next.is_div = 1'b1;
                sum_next.v_re = gia_pkg::VW'(in_data.p_rr) + gia_pkg::VW'(in_data.p_ii);
                sum_next.v_im = gia_pkg::VW'(in_data.p_ir) - gia_pkg::VW'(in_data.p_ri);
                sum_next.den  = gia_pkg::MW'(in_data.sq_r) + gia_pkg::MW'(in_data.sq_i);
            end
        endcase
    end

    // stage B: sign/magnitude split
    assign neg_re = -sum_reg.v_re;
    assign neg_im = -sum_reg.v_im;

    always_comb begin
        div_next.den_zero = sum_reg.is_div && (sum_reg.den == '0);
        div_next.neg_re   = sum_reg.v_re[gia_pkg::VW-1];
        div_next.neg_im   = sum_reg.v_im[gia_pkg::VW-1];
        div_next.den      = sum_reg.den;
        div_next.num_re   = sum_reg.v_re[gia_pkg::VW-1] ? neg_re[gia_pkg::MW-1:0]
                                                        : sum_reg.v_re[gia_pkg::MW-1:0];
        div_next.num_im   = sum_reg.v_im[gia_pkg::VW-1] ? neg_im[gia_pkg::MW-1:0]
                                                        : sum_reg.v_im[gia_pkg::MW-1:0];
        div_next.rem_re   = '0;
        div_next.rem_im   = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_valid_reg <= 1'b0;
            div_valid_reg <= 1'b0;
        end else if (en) begin
            sum_valid_reg <= in_valid;
            div_valid_reg <= sum_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg <= sum_next;
            div_reg <= div_next;
        end
    end

    assign out_valid = div_valid_reg;
    assign out_data  = div_reg;

endmodule

FILE: rtl/gia_dstage.sv
module gia_dstage (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  gia_pkg::div_t in_data,
    output logic          out_valid,
    output gia_pkg::div_t out_data
);

    gia_pkg::div_t data_next, data_reg;
    logic          valid_reg;
    logic [gia_pkg::MW-1:0] t_re, t_im;
    logic          q_re, q_im;

    // remainder stays below den <= 2^(MW-1), so the shift drops nothing
    assign t_re = {in_data.rem_re[gia_pkg::MW-2:0], in_data.num_re[gia_pkg::MW-1]};
    assign t_im = {in_data.rem_im[gia_pkg::MW-2:0], in_data.num_im[gia_pkg::MW-1]};
    assign q_re = (t_re >= in_data.den);
    assign q_im = (t_im >= in_data.den);

    always_comb begin
        data_next        = in_data;
        data_next.rem_re = q_re ? (t_re - in_data.den) : t_re;
        data_next.rem_im = q_im ? (t_im - in_data.den) : t_im;
        data_next.num_re = {in_data.num_re[gia_pkg::MW-2:0], q_re};
        data_next.num_im = {in_data.num_im[gia_pkg::MW-2:0], q_im};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: rtl/gia_checker.sv
module gia_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_res_re,
    input logic [31:0] m_res_im,
    input logic [1:0]  m_status
);

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_res_re) && $stable(m_res_im))
        else $error("stalled result beat changed");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("input ready does not follow output stall");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == gia_pkg::ST_DIV_ZERO || m_status == gia_pkg::ST_INEXACT)
        |-> m_res_re == '0 && m_res_im == '0)
        else $error("error result carries nonzero parts");

endmodule

bind gaussian_integer_alu_core gia_checker u_gia_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_res_re (m_res_re),
    .m_res_im (m_res_im),
    .m_status (m_status)
);
